@@ design/lfh_pkg.sv @@
// Package: shared types, constants and codes for the latched fault history log.
`timescale 1ns / 1ps
package lfh_pkg;

	localparam int DEPTH  = 32;
	localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int HIST_W = 6;

	typedef enum logic [1:0] {
		MODE_RECORD  = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_READ    = 2'd2,
		MODE_CLEAR   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ISSUE,
		S_LOAD,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [15:0]        flt_code;
		logic signed [15:0] rpm_snap;
		logic signed [31:0] vdc_link;
		logic signed [31:0] i_alpha;
	} req_beat_t;

	typedef struct packed {
		logic               record_valid;
		logic               is_last;
		logic [HIST_W-1:0]  history_count;
		logic               latched;
		logic [15:0]        active_code;
		logic [31:0]        entry_time;
		logic [15:0]        entry_code;
		logic signed [15:0] entry_speed;
		logic signed [31:0] entry_voltage;
		logic signed [31:0] entry_current;
	} rsp_beat_t;

	typedef struct packed {
		logic [31:0]        time_stamp;
		logic [15:0]        code;
		logic signed [15:0] speed;
		logic signed [31:0] voltage;
		logic signed [31:0] current;
	} snap_t;

	typedef struct packed {
		logic record;
		logic release_latch;
		logic clear;
		logic load_status;
		logic start_read;
		logic issue_read;
		logic load_entry;
	} cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic out_last;
	} stat_t;

endpackage

@@ design/lfh_req_if.sv @@
// Interface: request channel carrying one input beat.
`timescale 1ns / 1ps
interface lfh_req_if;
	import lfh_pkg::*;

	logic      valid;
	logic      ready;
	req_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/lfh_rsp_if.sv @@
// Interface: response channel carrying one result beat.
`timescale 1ns / 1ps
interface lfh_rsp_if;
	import lfh_pkg::*;

	logic      valid;
	logic      ready;
	rsp_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/latched_fault_history_log_top.sv @@
// Top level: latched fault history log with circular snapshot memory.
//
//  Channel  Dir  Beat                                   Handshake
//  req      in   mode, fault code, speed, V, I          valid/ready
//  rsp      out  status or history entry, is_last       valid/ready
//
// Record, release and clear take one beat in and give one beat out; the
// next request is taken once that result has been accepted. A history
// read gives count beats, newest first, each through the registered read
// port of the snapshot memory; an empty history gives one status beat.
// Reset clears pointer, count, latch, active code and timestamp; memory is
// not cleared. A stalled result holds the output register and the FSM.
`timescale 1ns / 1ps
module latched_fault_history_log_top (
	input logic        clk,
	input logic        arst_n,
	lfh_req_if.sink    req,
	lfh_rsp_if.source  rsp
);
	import lfh_pkg::*;

	cmd_t      cmd;
	stat_t     st;
	rsp_beat_t out_beat;

	lfh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_mode  (req.data.mode),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.st        (st),
		.cmd       (cmd)
	);

	lfh_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_beat  (req.data),
		.st       (st),
		.out_beat (out_beat)
	);

	assign rsp.data = out_beat;

endmodule

@@ design/lfh_ctrl.sv @@
// Controller: sequencing of record, release, clear and history read beats.
`timescale 1ns / 1ps
module lfh_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic [1:0]     req_mode,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	input  lfh_pkg::stat_t st,
	output lfh_pkg::cmd_t  cmd
);
	import lfh_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (req_mode == MODE_READ && !st.cnt_zero) begin
						state_nxt = S_ISSUE;
					end else begin
						state_nxt = S_OUT;
					end
				end
			end
			S_ISSUE: state_nxt = S_LOAD;
			S_LOAD:  state_nxt = S_OUT;
			S_OUT: begin
				if (rsp_ready) begin
					state_nxt = st.out_last ? S_IDLE : S_LOAD;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		rsp_valid = 1'b0;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					unique case (req_mode)
						MODE_RECORD: begin
							cmd.record      = 1'b1;
							cmd.load_status = 1'b1;
						end
						MODE_RELEASE: begin
							cmd.release_latch = 1'b1;
							cmd.load_status   = 1'b1;
						end
						MODE_CLEAR: begin
							cmd.clear       = 1'b1;
							cmd.load_status = 1'b1;
						end
						MODE_READ: begin
							if (st.cnt_zero) begin
								cmd.load_status = 1'b1;
							end else begin
								cmd.start_read = 1'b1;
							end
						end
						default: cmd.load_status = 1'b1;
					endcase
				end
			end
			S_ISSUE: cmd.issue_read = 1'b1;
			S_LOAD:  cmd.load_entry = 1'b1;
			S_OUT: begin
				rsp_valid = 1'b1;
				if (rsp_ready && !st.out_last) begin
					cmd.issue_read = 1'b1;
				end
			end
			default: ;
		endcase
	end

	a_ready_excl_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && rsp_valid))
		else $error("request taken while a result is pending");

	a_issue_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue_read |=> cmd.load_entry)
		else $error("memory read not followed by entry load");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("stalled result beat dropped");

endmodule

@@ design/lfh_dp.sv @@
// Datapath: snapshot memory, pointers, latch state and result register.
`timescale 1ns / 1ps
module lfh_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  lfh_pkg::cmd_t       cmd,
	input  lfh_pkg::req_beat_t  in_beat,
	output lfh_pkg::stat_t      st,
	output lfh_pkg::rsp_beat_t  out_beat
);
	import lfh_pkg::*;

	function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == '0) begin
			r = PTR_W'(DEPTH - 1);
		end else begin
			r = p - 1'b1;
		end
		return r;
	endfunction

	snap_t mem [DEPTH];

	logic [PTR_W-1:0] wp_q;
	logic [CNT_W-1:0] cnt_q;
	logic             latch_q;
	logic [15:0]      code_q;
	logic [31:0]      clock_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] rem_q;
	snap_t            rd_data_q;
	rsp_beat_t        out_q;

	logic             rec_take;
	logic [PTR_W-1:0] wp_nxt;
	logic [CNT_W-1:0] cnt_nxt;
	logic             latch_nxt;
	logic [15:0]      code_nxt;
	snap_t            wr_snap;
	rsp_beat_t        status_beat;
	rsp_beat_t        entry_beat;

	assign rec_take = cmd.record && !latch_q;

	always_comb begin
		wp_nxt    = wp_q;
		cnt_nxt   = cnt_q;
		latch_nxt = latch_q;
		code_nxt  = code_q;
		if (cmd.clear) begin
			wp_nxt  = '0;
			cnt_nxt = '0;
		end
		if (cmd.release_latch) begin
			latch_nxt = 1'b0;
			code_nxt  = '0;
		end
		if (rec_take) begin
			wp_nxt    = (wp_q == PTR_W'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			cnt_nxt   = (cnt_q == CNT_W'(DEPTH)) ? cnt_q : cnt_q + 1'b1;
			latch_nxt = 1'b1;
			code_nxt  = in_beat.flt_code;
		end
	end

	always_comb begin
		wr_snap.time_stamp = clock_q;
		wr_snap.code       = in_beat.flt_code;
		wr_snap.speed      = in_beat.rpm_snap;
		wr_snap.voltage    = in_beat.vdc_link;
		wr_snap.current    = in_beat.i_alpha;
	end

	always_comb begin
		status_beat               = '0;
		status_beat.is_last       = 1'b1;
		status_beat.history_count = HIST_W'(cnt_nxt);
		status_beat.latched       = latch_nxt;
		status_beat.active_code   = code_nxt;
	end

	always_comb begin
		entry_beat               = '0;
		entry_beat.record_valid  = 1'b1;
		entry_beat.is_last       = (rem_q == '0);
		entry_beat.history_count = HIST_W'(cnt_q);
		entry_beat.latched       = latch_q;
		entry_beat.active_code   = code_q;
		entry_beat.entry_time    = rd_data_q.time_stamp;
		entry_beat.entry_code    = rd_data_q.code;
		entry_beat.entry_speed   = rd_data_q.speed;
		entry_beat.entry_voltage = rd_data_q.voltage;
		entry_beat.entry_current = rd_data_q.current;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			cnt_q    <= '0;
			latch_q  <= 1'b0;
			code_q   <= '0;
			clock_q  <= '0;
			rd_ptr_q <= '0;
			rem_q    <= '0;
		end else begin
			wp_q    <= wp_nxt;
			cnt_q   <= cnt_nxt;
			latch_q <= latch_nxt;
			code_q  <= code_nxt;
			if (rec_take) begin
				clock_q <= clock_q + 1'b1;
			end
			if (cmd.start_read) begin
				rd_ptr_q <= ptr_dec(wp_q);
				rem_q    <= cnt_q;
			end else if (cmd.issue_read) begin
				rd_ptr_q <= ptr_dec(rd_ptr_q);
				rem_q    <= rem_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rec_take) begin
			mem[wp_q] <= wr_snap;
		end
		if (cmd.issue_read) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_status) begin
			out_q <= status_beat;
		end else if (cmd.load_entry) begin
			out_q <= entry_beat;
		end
	end

	assign st.cnt_zero = (cnt_q == '0);
	assign st.out_last = out_q.is_last;
	assign out_beat    = out_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q <= CNT_W'(DEPTH)) && (wp_q <= PTR_W'(DEPTH - 1)))
		else $error("history count or pointer out of range");

	a_record_closes: assert property (@(posedge clk) disable iff (!arst_n)
		rec_take |=> latch_q && (cnt_q != '0))
		else $error("record did not close latch");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (cnt_q == '0) && (wp_q == '0))
		else $error("clear left history behind");

endmodule
